/* sv/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
// Each macro expands to one labelled concurrent assertion, sampled on the
// rising clock edge and switched off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Implication checked in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sstt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted sparse triplet table package
// Sizes, entry layout, status codes and register indexes shared by the
// table unit, its checker and the testbench.
// ----------------------------------------------------------------------------
package sstt_pkg;

  // Matrix and table dimensions.
  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int CAPACITY   = 256;
  localparam int VALUE_BITS = 32;

  // Field widths.
  localparam int ROW_W    = 4;
  localparam int COL_W    = 4;
  localparam int LIM_W    = 5;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CFG_IDX_W = 1;

  // Reset values of the limit registers.
  localparam logic [LIM_W-1:0] ROW_LIMIT_RESET = LIM_W'(10);
  localparam logic [LIM_W-1:0] COL_LIMIT_RESET = LIM_W'(10);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_LIMIT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

  // Operation codes of the func field.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // One stored triplet; row and column together form the row-major key.
  typedef struct packed {
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* sv/sstt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sstt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/sorted_sparse_triplet_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted sparse triplet table unit
// Stores a sparse matrix as (row, column, value) triplets in row-major order
// and serves reads, overwrites and sorted inserts, one item at a time.
// ----------------------------------------------------------------------------
// Each item gives one result. The triplets sit in one 256-entry memory with a
// single read and a single write port, and the memory port sets the timing:
// the search reads the entries one at a time from the start of the table, each
// read followed by a compare state, and an insert at position p moves the
// n - p entries above it up by one (read, then write back) from the top down
// before it fills the gap. An out-of-range position skips the search. The
// next item is accepted once the current one has been handed to the output
// register, so a result may wait there while the following item is worked on.
// The memory needs no clearing after reset: only entries below the stored
// count are ever read.
// ----------------------------------------------------------------------------
module sorted_sparse_triplet_table_unit
  import sstt_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [LIM_W-1:0]             cfg_data_i,
  // Input item channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [ROW_W-1:0]             row_index_i,
  input  logic [COL_W-1:0]             col_index_i,
  input  logic signed [VALUE_BITS-1:0] write_value_i,
  // Result item channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic signed [VALUE_BITS-1:0] read_value_o,
  output logic [CNT_W-1:0]             entry_count_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_SHR  = 6'b001000,
    S_SHW  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [LIM_W-1:0]      row_limit_q, col_limit_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic [ADDR_W-1:0]     m_q, m_d;
  logic                  func_q;
  logic [ROW_W-1:0]      row_q;
  logic [COL_W-1:0]      col_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [VALUE_BITS-1:0] res_value_q, res_value_d;

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q;
  logic [VALUE_BITS-1:0] out_value_q;
  logic [CNT_W-1:0]      out_count_q;

  logic                  in_accept;
  logic                  out_load;
  logic                  out_of_range;
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  entry_t                ram_wdata, ram_rdata;
  logic [ROW_W+COL_W-1:0] rd_key, req_key;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Position check against the configured limits and the matrix size.
  assign out_of_range = ({1'b0, row_index_i} >= row_limit_q)
                     || ({1'b0, col_index_i} >= col_limit_q)
                     || ({1'b0, row_index_i} >= LIM_W'(MAX_ROWS))
                     || ({1'b0, col_index_i} >= LIM_W'(MAX_COLS));

  assign rd_key  = {ram_rdata.row, ram_rdata.col};
  assign req_key = {row_q, col_q};

  // Limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_limit_q <= ROW_LIMIT_RESET;
      col_limit_q <= COL_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ROW_LIMIT: row_limit_q <= cfg_data_i;
        REG_COL_LIMIT: col_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: search, then update, insert by shifting, or report.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    k_d          = k_q;
    m_d          = m_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    ram_we       = 1'b0;
    ram_waddr    = m_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = k_q[ADDR_W-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          k_d         = '0;
          res_value_d = '0;
          if (out_of_range) begin
            res_status_d = ST_RANGE;
            state_d      = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end

      // Read the next entry, or stop at the end of the stored triplets.
      S_RD: begin
        if (k_q == count_q) begin
          if (func_q == FUNC_READ) begin
            res_status_d = ST_MISS;
            state_d      = S_DONE;
          end else if (count_q == CNT_W'(CAPACITY)) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            m_d     = count_q[ADDR_W-1:0];
            state_d = S_SHR;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_CMP;
        end
      end

      // The first entry whose key is not below the requested key ends the search.
      S_CMP: begin
        if (rd_key >= req_key) begin
          if (rd_key == req_key) begin
            if (func_q == FUNC_READ) begin
              res_status_d = ST_HIT;
              res_value_d  = ram_rdata.value;
            end else begin
              ram_we       = 1'b1;
              ram_waddr    = k_q[ADDR_W-1:0];
              ram_wdata    = '{row: row_q, col: col_q, value: val_q};
              res_status_d = ST_UPDATED;
            end
            state_d = S_DONE;
          end else if (func_q == FUNC_READ) begin
            res_status_d = ST_MISS;
            state_d      = S_DONE;
          end else if (count_q == CNT_W'(CAPACITY)) begin
            res_status_d = ST_FULL;
            state_d      = S_DONE;
          end else begin
            m_d     = count_q[ADDR_W-1:0];
            state_d = S_SHR;
          end
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = S_RD;
        end
      end

      // Shift from the top down; once the gap reaches the slot, fill it.
      S_SHR: begin
        if (m_q == k_q[ADDR_W-1:0]) begin
          ram_we       = 1'b1;
          ram_waddr    = m_q;
          ram_wdata    = '{row: row_q, col: col_q, value: val_q};
          count_d      = count_q + CNT_W'(1);
          res_status_d = ST_INSERTED;
          state_d      = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = m_q - ADDR_W'(1);
          state_d   = S_SHW;
        end
      end

      S_SHW: begin
        ram_we    = 1'b1;
        ram_waddr = m_q;
        ram_wdata = ram_rdata;
        m_d       = m_q - ADDR_W'(1);
        state_d   = S_SHR;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    m_q          <= m_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (in_accept) begin
      func_q <= func_i;
      row_q  <= row_index_i;
      col_q  <= col_index_i;
      val_q  <= write_value_i;
    end
  end

  // Output register: holds a result item until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_value_q;
  assign entry_count_o = out_count_q;

  // Triplet store.
  sstt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

/* sv/sstt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted sparse triplet table checker
// Watches the ports of the table unit and checks the results it hands out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sstt_checker
  import sstt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [STATUS_W-1:0]   status_o,
  input logic [VALUE_BITS-1:0] read_value_o,
  input logic [CNT_W-1:0]      entry_count_o
);

  // A shown result reports one of the defined outcomes.
  `ASSERT_IMPLIES(a_status_known, clk_i, rst_ni, out_valid_o, status_o <= ST_FULL, "status code outside the defined set")

  // Only a read hit carries a value.
  `ASSERT_IMPLIES(a_value_on_hit, clk_i, rst_ni, out_valid_o && (status_o != ST_HIT), read_value_o == '0, "nonzero value on a result other than a read hit")

  // A full table is reported only when every slot is taken.
  `ASSERT_IMPLIES(a_full_count, clk_i, rst_ni, out_valid_o && (status_o == ST_FULL), entry_count_o == CNT_W'(CAPACITY), "table full reported below capacity")

  // An insert always leaves at least one stored triplet, never more than fit.
  `ASSERT_IMPLIES(a_insert_count, clk_i, rst_ni, out_valid_o && (status_o == ST_INSERTED), (entry_count_o != '0) && (entry_count_o <= CNT_W'(CAPACITY)), "entry count inconsistent with an insert")

  // A stalled result stays on the port.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(entry_count_o), "stalled result item changed")

endmodule

bind sorted_sparse_triplet_table_unit sstt_checker u_sstt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .read_value_o  (read_value_o),
  .entry_count_o (entry_count_o)
);

/* tb/tb_sorted_sparse_triplet_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sorted sparse triplet table unit
// Drives reads and writes through the stall handshake, predicts every result
// with a mirror of the triplet table and compares each field as it arrives.
// Phases cover the reset limits, zero limits, a single-element matrix, limits
// above the matrix size, a completely filled table and a mixed setting at the end.
// ----------------------------------------------------------------------------
module tb_sorted_sparse_triplet_table_unit;
  import sstt_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic                  func;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [VALUE_BITS-1:0] value;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [VALUE_BITS-1:0] read_value;
    logic [CNT_W-1:0]      entry_count;
  } table_result_t;

  // Block ports.
  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i   = '0;
  logic [LIM_W-1:0]             cfg_data_i    = '0;
  logic                         in_valid_i    = 1'b0;
  logic                         in_stall_o;
  logic                         func_i        = FUNC_WRITE;
  logic [ROW_W-1:0]             row_index_i   = '0;
  logic [COL_W-1:0]             col_index_i   = '0;
  logic signed [VALUE_BITS-1:0] write_value_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [STATUS_W-1:0]          status_o;
  logic signed [VALUE_BITS-1:0] read_value_o;
  logic [CNT_W-1:0]             entry_count_o;

  // Mirror of the triplet table and of the limit registers.
  logic [ROW_W-1:0]      mirror_row   [CAPACITY];
  logic [COL_W-1:0]      mirror_col   [CAPACITY];
  logic [VALUE_BITS-1:0] mirror_value [CAPACITY];
  int                    mirror_count = 0;
  logic [LIM_W-1:0]      row_lim      = ROW_LIMIT_RESET;
  logic [LIM_W-1:0]      col_lim      = COL_LIMIT_RESET;

  table_op_t     pending_ops[$];
  table_result_t expected_results[$];

  int queued_items   = 0;
  int accepted_items = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  // Sender and receiver pacing.
  table_op_t tx_item  = '0;
  bit        tx_busy  = 1'b0;
  bit        tx_calm  = 1'b0;
  int        tx_wait  = 0;
  bit        rx_calm  = 1'b0;
  int        rx_wait  = 0;
  logic      rx_stall = 1'b0;
  logic      hold_off = 1'b0;

  assign out_stall_i = rx_stall | hold_off;

  sorted_sparse_triplet_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .write_value_i (write_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  // Clock generation.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one item to the mirror table and returns the result it gives.
  function automatic table_result_t apply_table_op(table_op_t op);
    table_result_t res;
    int            rlim;
    int            clim;
    int            k;
    int            m;
    bit            hit;
    rlim = (int'(row_lim) > MAX_ROWS) ? MAX_ROWS : int'(row_lim);
    clim = (int'(col_lim) > MAX_COLS) ? MAX_COLS : int'(col_lim);
    res.read_value = '0;
    if (int'(op.row) >= rlim || int'(op.col) >= clim) begin
      res.status = ST_RANGE;
    end else begin
      // Row-major search for the first key not below the addressed one.
      k = 0;
      while (k < mirror_count && op.row > mirror_row[k]) k++;
      while (k < mirror_count && op.row == mirror_row[k] && op.col > mirror_col[k]) k++;
      hit = (k < mirror_count) && (mirror_row[k] == op.row) && (mirror_col[k] == op.col);
      if (op.func == FUNC_READ) begin
        if (hit) begin
          res.status     = ST_HIT;
          res.read_value = mirror_value[k];
        end else begin
          res.status = ST_MISS;
        end
      end else if (hit) begin
        mirror_value[k] = op.value;
        res.status      = ST_UPDATED;
      end else if (mirror_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        for (m = mirror_count; m > k; m--) begin
          mirror_row[m]   = mirror_row[m-1];
          mirror_col[m]   = mirror_col[m-1];
          mirror_value[m] = mirror_value[m-1];
        end
        mirror_row[k]   = op.row;
        mirror_col[k]   = op.col;
        mirror_value[k] = op.value;
        mirror_count++;
        res.status = ST_INSERTED;
      end
    end
    res.entry_count = CNT_W'(mirror_count);
    return res;
  endfunction

  // Mostly inside the current limit, sometimes anywhere in the index range.
  function automatic logic [3:0] pick_index(int lim, int cap);
    int eff;
    eff = (lim > cap) ? cap : lim;
    if (eff > 0 && $urandom_range(0, 99) < 85) return 4'($urandom_range(0, eff - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_op(logic func, logic [3:0] row, logic [3:0] col,
                         logic [VALUE_BITS-1:0] value);
    table_op_t op;
    op.func  = func;
    op.row   = row;
    op.col   = col;
    op.value = value;
    pending_ops.push_back(op);
    queued_items++;
  endtask

  task automatic push_random_ops(int n);
    repeat (n) begin
      push_op(($urandom_range(0, 99) < 45) ? FUNC_READ : FUNC_WRITE,
              pick_index(int'(row_lim), MAX_ROWS), pick_index(int'(col_lim), MAX_COLS),
              pick_value());
    end
  endtask

  // Waits until every queued item has been taken and answered.
  task automatic wait_idle();
    while (accepted_items != queued_items || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_ROW_LIMIT) row_lim = data;
    else                      col_lim = data;
  endtask

  task automatic flag_error(string msg);
    if (error_count < MAX_PRINTED) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Driver: presents queued items, with a random gap before each one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_busy    = 1'b0;
      tx_wait    = $urandom_range(0, 10);
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_table_op(tx_item));
        accepted_items++;
        if (accepted_items % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        tx_wait = tx_calm ? 0 : $urandom_range(0, 10);
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_ops.size() > 0) begin
          tx_item = pending_ops.pop_front();
          tx_busy = 1'b1;
        end
      end
      in_valid_i    <= tx_busy;
      func_i        <= tx_item.func;
      row_index_i   <= tx_item.row;
      col_index_i   <= tx_item.col;
      write_value_i <= tx_item.value;
    end
  end

  // Monitor: takes results after a random stall and checks every field.
  always @(posedge clk_i) begin
    table_result_t exp_r;
    if (!rst_ni) begin
      rx_stall <= 1'b0;
      rx_wait  = $urandom_range(0, 10);
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result with nothing expected: status %0d count %0d",
                               status_o, entry_count_o));
        end else begin
          exp_r = expected_results.pop_front();
          if (status_o !== exp_r.status)
            flag_error($sformatf("item %0d status: got %0d, want %0d",
                                 results_seen, status_o, exp_r.status));
          if (read_value_o !== exp_r.read_value)
            flag_error($sformatf("item %0d read_value: got %h, want %h",
                                 results_seen, read_value_o, exp_r.read_value));
          if (entry_count_o !== exp_r.entry_count)
            flag_error($sformatf("item %0d entry_count: got %0d, want %0d",
                                 results_seen, entry_count_o, exp_r.entry_count));
        end
        if (results_seen % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
      end else if (out_valid_o && rx_wait > 0) begin
        rx_wait--;
      end
      rx_stall <= (rx_wait > 0);
    end
  end

  // Long hold-off on the result side, so that the block backs up.
  initial begin
    wait (results_seen >= 40);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog on the run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int order [CAPACITY];
    int j;
    int tmp;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at the reset limits of ten by ten.
    push_op(FUNC_READ,  4'd0,  4'd0,  '0);            // miss on an empty table
    push_op(FUNC_WRITE, 4'd0,  4'd0,  32'h8000_0000); // most negative value
    push_op(FUNC_WRITE, 4'd9,  4'd9,  32'h7FFF_FFFF); // last position, most positive
    push_op(FUNC_WRITE, 4'd5,  4'd3,  32'hFFFF_FFFF);
    push_op(FUNC_WRITE, 4'd0,  4'd9,  32'h0000_0000); // a zero is stored like any value
    push_op(FUNC_WRITE, 4'd9,  4'd0,  32'h0000_0001);
    push_op(FUNC_READ,  4'd0,  4'd0,  32'hFFFF_FFFF);
    push_op(FUNC_READ,  4'd9,  4'd9,  '0);
    push_op(FUNC_READ,  4'd0,  4'd9,  '0);
    push_op(FUNC_READ,  4'd5,  4'd4,  '0);
    push_op(FUNC_WRITE, 4'd5,  4'd3,  32'h1234_5678); // overwrite
    push_op(FUNC_READ,  4'd5,  4'd3,  '0);
    push_op(FUNC_WRITE, 4'd10, 4'd0,  32'hDEAD_BEEF); // row on the limit
    push_op(FUNC_WRITE, 4'd0,  4'd10, 32'hDEAD_BEEF); // column on the limit
    push_op(FUNC_READ,  4'd15, 4'd15, '0);
    push_op(FUNC_READ,  4'd10, 4'd9,  '0);
    push_op(FUNC_WRITE, 4'd15, 4'd0,  32'h5555_5555);
    push_op(FUNC_WRITE, 4'd4,  4'd2,  32'hA5A5_A5A5); // insert in the middle
    push_op(FUNC_WRITE, 4'd0,  4'd0,  32'h0000_0000); // overwrite with zero
    push_op(FUNC_READ,  4'd0,  4'd0,  '0);
    push_op(FUNC_READ,  4'd9,  4'd0,  '0);
    push_random_ops(200);
    wait_idle();

    // A limit of zero puts every position out of range.
    write_reg(REG_ROW_LIMIT, 5'd0);
    push_random_ops(20);
    wait_idle();
    write_reg(REG_ROW_LIMIT, 5'd10);
    write_reg(REG_COL_LIMIT, 5'd0);
    push_random_ops(15);
    wait_idle();

    // Smallest useful matrix: a single element.
    write_reg(REG_ROW_LIMIT, 5'd1);
    write_reg(REG_COL_LIMIT, 5'd1);
    push_random_ops(30);
    wait_idle();

    // Limits above the matrix size act as the full size.
    write_reg(REG_ROW_LIMIT, 5'd31);
    write_reg(REG_COL_LIMIT, 5'd17);
    push_random_ops(250);
    wait_idle();

    // Write every position in shuffled order, so that the table ends full.
    write_reg(REG_ROW_LIMIT, 5'd16);
    write_reg(REG_COL_LIMIT, 5'd16);
    for (j = 0; j < CAPACITY; j++) order[j] = j;
    for (j = CAPACITY - 1; j > 0; j--) begin
      tmp = $urandom_range(0, j);
      {order[j], order[tmp]} = {order[tmp], order[j]};
    end
    for (j = 0; j < CAPACITY; j++)
      push_op(FUNC_WRITE, 4'(order[j] / 16), 4'(order[j] % 16), pick_value());
    push_random_ops(250);
    wait_idle();

    // A mixed setting on the full table.
    write_reg(REG_ROW_LIMIT, 5'd5);
    write_reg(REG_COL_LIMIT, 5'd12);
    push_random_ops(130);
    wait_idle();

    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/sstt_pkg.sv
sv/sstt_ram.sv
sv/sorted_sparse_triplet_table_unit.sv
sv/sstt_checker.sv
tb/tb_sorted_sparse_triplet_table_unit.sv
